@@ hdl/two_level_page_table_inserter_top_defines.svh @@
// assertion macros shared by the page table inserter modules
`ifndef TWO_LEVEL_PAGE_TABLE_INSERTER_TOP_DEFINES_SVH
`define TWO_LEVEL_PAGE_TABLE_INSERTER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define TLPT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define TLPT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define TLPT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define TLPT_ASSERT(lbl, clk, rstn, prop, msg)
`define TLPT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define TLPT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ hdl/tlpt_pkg.sv @@
// shared constants, codes and control structs of the page table inserter
`default_nettype none
package tlpt_pkg;

  localparam int POOL_TABLES_DEF = 64;
  localparam int COARSE_ENTRIES  = 256;
  localparam int L1_DEPTH        = 4096;
  localparam int L1_AW           = 12;
  localparam int L2_AW           = 8;
  localparam int BASE_W          = 22;
  localparam int WORD_W          = 32;
  localparam int STATUS_W        = 3;
  localparam int SLOT_OUT_W      = 6;
  localparam int CODE_W          = 4;

  localparam logic [WORD_W-1:0] L1_DEFAULT   = 32'h0000_0010;
  localparam logic [11:0]       AP_ALL_RW    = 12'hFF0;
  localparam logic [1:0]        TYPE_NONE    = 2'b00;
  localparam logic [1:0]        TYPE_COARSE  = 2'b01;
  localparam logic [1:0]        TYPE_SMALL   = 2'b10;
  localparam logic [CODE_W-1:0] FAULT_PAGE    = 4'b0111;
  localparam logic [CODE_W-1:0] FAULT_SECTION = 4'b0101;
  localparam logic              KIND_INSERT  = 1'b0;

  localparam logic [STATUS_W-1:0] ST_INSERTED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXISTS      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_POOL_FULL   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN     = 3'd5;

  typedef struct packed {
    logic accept;
    logic eval1;
    logic eval2;
    logic load_out;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic need_l2;
    logic out_busy;
  } st_t;

endpackage
`default_nettype wire

@@ hdl/tlpt_if.sv @@
// input and result channel interfaces of the page table inserter
`default_nettype none
interface tlpt_in_if import tlpt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [WORD_W-1:0] virtual_address;
  logic [WORD_W-1:0] page_entry;
  logic              flag_duplicates;
  logic [CODE_W-1:0] fault_code;

  modport source (output valid, kind, virtual_address, page_entry, flag_duplicates,
                  fault_code, input ready);
  modport sink (input valid, kind, virtual_address, page_entry, flag_duplicates,
                fault_code, output ready);
endinterface

interface tlpt_out_if import tlpt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic                  created_table;
  logic [SLOT_OUT_W-1:0] pool_slot;
  logic [WORD_W-1:0]     first_level_word;
  logic [WORD_W-1:0]     second_level_word;

  modport source (output valid, status, created_table, pool_slot, first_level_word,
                  second_level_word, input ready);
  modport sink (input valid, status, created_table, pool_slot, first_level_word,
                second_level_word, output ready);
endinterface
`default_nettype wire

@@ hdl/tlpt_ctrl.sv @@
// controller state machine: clearing sweep, item sequencing, result hand-off
`default_nettype none
`include "two_level_page_table_inserter_top_defines.svh"
module tlpt_ctrl import tlpt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire st_t  st,
  output cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EVAL1 = 5'b00100,
    S_EVAL2 = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EVAL1;
        end
      end
      S_EVAL1: begin
        cmd.eval1 = 1'b1;
        state_nxt = st.need_l2 ? S_EVAL2 : S_DONE;
      end
      S_EVAL2: begin
        cmd.eval2 = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // wait until the output register can take the beat
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `TLPT_ASSERT(a_cmd_onehot, clk, rst_n,
    $onehot0({cmd.accept, cmd.eval1, cmd.eval2, cmd.load_out, cmd.clr_step}),
    "more than one datapath command at once")
  `TLPT_ASSERT_NXT(a_clear_to_idle, clk, rst_n, (state_r == S_CLEAR) && st.clr_last,
    state_r == S_IDLE, "clearing sweep did not end in idle")
  `TLPT_ASSERT_NXT(a_short_item, clk, rst_n, cmd.eval1 && !st.need_l2,
    state_r == S_DONE, "item without second-level read did not finish")

endmodule
`default_nettype wire

@@ hdl/tlpt_dp.sv @@
// datapath: table memories, pool counter, decode of descriptors, result registers
`default_nettype none
`include "two_level_page_table_inserter_top_defines.svh"
module tlpt_dp import tlpt_pkg::*; #(
  parameter int POOL_TABLES = POOL_TABLES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cmd_t                  cmd,
  output st_t                        st,
  input  wire logic                  cfg_we,
  input  wire logic [BASE_W-1:0]     cfg_wdata,
  input  wire logic                  in_kind,
  input  wire logic [WORD_W-1:0]     in_virtual_address,
  input  wire logic [WORD_W-1:0]     in_page_entry,
  input  wire logic                  in_flag_duplicates,
  input  wire logic [CODE_W-1:0]     in_fault_code,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic [STATUS_W-1:0]        out_status,
  output logic                       out_created_table,
  output logic [SLOT_OUT_W-1:0]      out_pool_slot,
  output logic [WORD_W-1:0]          out_first_level_word,
  output logic [WORD_W-1:0]          out_second_level_word
);

  localparam int SLOT_W       = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
  localparam int UW           = $clog2(POOL_TABLES + 1);
  localparam int COARSE_AW    = SLOT_W + L2_AW;
  localparam int COARSE_DEPTH = POOL_TABLES * COARSE_ENTRIES;
  localparam int CLR_LEN      = (COARSE_DEPTH > L1_DEPTH) ? COARSE_DEPTH : L1_DEPTH;
  localparam int CLR_W        = $clog2(CLR_LEN);

  logic [WORD_W-1:0] l1_mem [L1_DEPTH];
  logic [WORD_W-1:0] c_mem  [COARSE_DEPTH];

  logic [BASE_W-1:0] base_r;
  logic [UW-1:0]     pool_used_r, pool_used_nxt;
  logic [CLR_W-1:0]  clr_cnt_r;
  logic              out_valid_r, out_valid_nxt;

  logic              go_r;
  logic              flag_r;
  logic [WORD_W-1:0] entry_r;
  logic [L1_AW-1:0]  i1_r;
  logic [L2_AW-1:0]  i2_r;
  logic [SLOT_W-1:0] slot_r;
  logic [WORD_W-1:0] l1_rd_r;
  logic [WORD_W-1:0] l2_rd_r;

  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                res_created_r, res_created_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic [WORD_W-1:0]   res_word_r, res_word_nxt;
  logic [WORD_W-1:0]   res_l2_r, res_l2_nxt;

  logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;

  logic                 in_go;
  logic [WORD_W-1:0]    in_entry;
  logic [BASE_W-1:0]    used_ext;
  logic [BASE_W-1:0]    diff;
  logic                 resolved;
  logic                 pool_full;
  logic                 fresh;
  logic                 l2_fill;
  logic [SLOT_W-1:0]    fresh_slot;
  logic [BASE_W-1:0]    fresh_base;
  logic [WORD_W-1:0]    fresh_word;
  logic                 clr_c_en;

  logic                 l1_we;
  logic [L1_AW-1:0]     l1_wa;
  logic [WORD_W-1:0]    l1_wd;
  logic                 c_we;
  logic [COARSE_AW-1:0] c_wa;
  logic [WORD_W-1:0]    c_wd;

  // page and section fault beats become a read/write small page with duplicates flagged
  assign in_go    = (in_kind == KIND_INSERT) || (in_fault_code == FAULT_PAGE) ||
                    (in_fault_code == FAULT_SECTION);
  assign in_entry = (in_kind == KIND_INSERT) ? in_page_entry :
                    {in_virtual_address[WORD_W-1:12], AP_ALL_RW[11:2], TYPE_SMALL};

  // first-level decode
  assign used_ext   = {{(BASE_W-UW){1'b0}}, pool_used_r};
  assign diff       = l1_rd_r[WORD_W-1:10] - base_r;
  assign resolved   = (l1_rd_r[1:0] == TYPE_COARSE) && (diff < used_ext);
  assign pool_full  = (pool_used_r == UW'(POOL_TABLES));
  assign fresh_slot = pool_used_r[SLOT_W-1:0];
  assign fresh_base = base_r + used_ext;
  assign fresh_word = {fresh_base, L1_DEFAULT[9:2], TYPE_COARSE};
  assign fresh      = cmd.eval1 && go_r && (l1_rd_r[1:0] == TYPE_NONE) && !pool_full;
  assign l2_fill    = cmd.eval2 && go_r && (l2_rd_r[1:0] == TYPE_NONE);

  assign clr_c_en = ({1'b0, clr_cnt_r} < (CLR_W+1)'(COARSE_DEPTH));

  always_comb begin
    l1_we = 1'b0;
    l1_wa = i1_r;
    l1_wd = fresh_word;
    c_we  = 1'b0;
    c_wa  = {fresh_slot, i2_r};
    c_wd  = entry_r;
    if (cmd.clr_step) begin
      l1_we = 1'b1;
      l1_wa = clr_cnt_r[L1_AW-1:0];
      l1_wd = L1_DEFAULT;
      c_we  = clr_c_en;
      c_wa  = clr_cnt_r[COARSE_AW-1:0];
      c_wd  = '0;
    end else if (fresh) begin
      l1_we = 1'b1;
      c_we  = 1'b1;
    end else if (l2_fill) begin
      c_we = 1'b1;
      c_wa = {slot_r, i2_r};
    end
  end

  always_ff @(posedge clk) begin
    if (l1_we) l1_mem[l1_wa] <= l1_wd;
    if (cmd.accept) l1_rd_r <= l1_mem[in_virtual_address[WORD_W-1:20]];
  end

  always_ff @(posedge clk) begin
    if (c_we) c_mem[c_wa] <= c_wd;
    if (cmd.eval1) l2_rd_r <= c_mem[{diff[SLOT_W-1:0], i2_r}];
  end

  always_comb begin
    pool_used_nxt   = pool_used_r;
    res_status_nxt  = res_status_r;
    res_created_nxt = res_created_r;
    res_slot_nxt    = res_slot_r;
    res_word_nxt    = res_word_r;
    res_l2_nxt      = res_l2_r;
    if (cmd.eval1) begin
      res_created_nxt = 1'b0;
      res_slot_nxt    = '0;
      res_word_nxt    = l1_rd_r;
      res_l2_nxt      = '0;
      res_status_nxt  = ST_UNSUPPORTED;
      if (!go_r) begin
        res_status_nxt = ST_UNKNOWN;
      end else if (l1_rd_r[1:0] == TYPE_NONE) begin
        if (pool_full) begin
          res_status_nxt = ST_POOL_FULL;
        end else begin
          pool_used_nxt   = pool_used_r + 1'b1;
          res_status_nxt  = ST_INSERTED;
          res_created_nxt = 1'b1;
          res_slot_nxt    = fresh_slot;
          res_word_nxt    = fresh_word;
          res_l2_nxt      = entry_r;
        end
      end
    end else if (cmd.eval2) begin
      res_l2_nxt = l2_rd_r;
      if (!go_r) begin
        res_status_nxt = ST_UNKNOWN;
        res_slot_nxt   = '0;
      end else begin
        res_slot_nxt = slot_r;
        priority if (l2_rd_r[1:0] == TYPE_SMALL) begin
          res_status_nxt = flag_r ? ST_DUPLICATE : ST_EXISTS;
        end else if (l2_rd_r[1:0] != TYPE_NONE) begin
          res_status_nxt = ST_UNSUPPORTED;
        end else begin
          res_status_nxt = ST_INSERTED;
          res_l2_nxt     = entry_r;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      pool_used_r <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) base_r <= cfg_wdata;
      pool_used_r <= pool_used_nxt;
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + 1'b1;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      go_r    <= in_go;
      flag_r  <= (in_kind == KIND_INSERT) ? in_flag_duplicates : 1'b1;
      entry_r <= in_entry;
      i1_r    <= in_virtual_address[WORD_W-1:20];
      i2_r    <= in_virtual_address[19:12];
    end
    if (cmd.eval1) slot_r <= diff[SLOT_W-1:0];
    res_status_r  <= res_status_nxt;
    res_created_r <= res_created_nxt;
    res_slot_r    <= res_slot_nxt;
    res_word_r    <= res_word_nxt;
    res_l2_r      <= res_l2_nxt;
    if (cmd.load_out) begin
      out_status            <= res_status_r;
      out_created_table     <= res_created_r;
      out_pool_slot         <= slot_ext[SLOT_OUT_W-1:0];
      out_first_level_word  <= res_word_r;
      out_second_level_word <= res_l2_r;
    end
  end

  assign slot_ext  = {{SLOT_OUT_W{1'b0}}, res_slot_r};
  assign out_valid = out_valid_r;

  assign st.clr_last = (clr_cnt_r == CLR_W'(CLR_LEN - 1));
  assign st.need_l2  = resolved;
  assign st.out_busy = out_valid_r && !out_ready;

  `TLPT_ASSERT(a_pool_bound, clk, rst_n, pool_used_r <= UW'(POOL_TABLES),
    "pool count beyond pool size")
  `TLPT_ASSERT_NXT(a_pool_take, clk, rst_n, fresh,
    pool_used_r == $past(pool_used_r) + 1'b1, "new table did not advance pool count")

endmodule
`default_nettype wire

@@ hdl/two_level_page_table_inserter_top.sv @@
// Two-level page table inserter, top level.
// The first-level word is read as an input beat is accepted, then decoded; when
// the entry lands in an existing coarse table, a coarse read and decode follow
// (first-level read, then coarse read). The result then goes to the output
// register, and only after that load is a new item taken. Reset: a sweep
// clears both tables with in_ch.ready low; config writes are taken meanwhile.
`default_nettype none
module two_level_page_table_inserter_top import tlpt_pkg::*; #(
  parameter int POOL_TABLES = POOL_TABLES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [BASE_W-1:0] cfg_wdata,
  tlpt_in_if.sink                in_ch,
  tlpt_out_if.source             out_ch
);

  cmd_t cmd;
  st_t  st;
  logic in_ready;

  assign in_ch.ready = in_ready;

  tlpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  tlpt_dp #(
    .POOL_TABLES (POOL_TABLES)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .st                    (st),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .in_kind               (in_ch.kind),
    .in_virtual_address    (in_ch.virtual_address),
    .in_page_entry         (in_ch.page_entry),
    .in_flag_duplicates    (in_ch.flag_duplicates),
    .in_fault_code         (in_ch.fault_code),
    .out_ready             (out_ch.ready),
    .out_valid             (out_ch.valid),
    .out_status            (out_ch.status),
    .out_created_table     (out_ch.created_table),
    .out_pool_slot         (out_ch.pool_slot),
    .out_first_level_word  (out_ch.first_level_word),
    .out_second_level_word (out_ch.second_level_word)
  );

endmodule
`default_nettype wire

@@ tb/tb_two_level_page_table_inserter_top.sv @@
// testbench for the two-level page table inserter: directed and random inserts and faults
`timescale 1ns / 1ps
module tb_two_level_page_table_inserter_top;
  import tlpt_pkg::*;

  localparam int POOL_N       = POOL_TABLES_DEF;
  localparam int HOT_N        = 10;
  localparam int PHASE_ITEMS  = 530;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int SETTLE_TICKS = 4;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic                  created;
    logic [SLOT_OUT_W-1:0] slot;
    logic [WORD_W-1:0]     l1_word;
    logic [WORD_W-1:0]     l2_word;
  } page_result_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [BASE_W-1:0] cfg_wdata;

  tlpt_in_if  in_if ();
  tlpt_out_if out_if ();

  two_level_page_table_inserter_top #(
    .POOL_TABLES(POOL_N)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_if),
    .out_ch   (out_if)
  );

  // predicted page table contents
  logic [WORD_W-1:0] l1_table [L1_DEPTH];
  logic [WORD_W-1:0] coarse_mem [POOL_N*COARSE_ENTRIES];
  int unsigned       tables_taken;
  logic [BASE_W-1:0] pool_base;

  page_result_t      expected_results [$];
  logic [L1_AW-1:0]  hot_index [3][HOT_N];
  int                status_count [8];
  int                src_idle_pct;
  int                sink_idle_pct;
  int                items_sent;
  int                results_checked;
  int                errors;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("FAILURE");
    $finish;
  end

  function automatic bit resolve_table(logic [WORD_W-1:0] word, output int unsigned slot);
    logic [BASE_W-1:0] offset;
    offset = word[31:10] - pool_base;
    slot = offset;
    return (word[1:0] == TYPE_COARSE) && (offset < tables_taken);
  endfunction

  function automatic page_result_t predict_insert(logic kind, logic [WORD_W-1:0] va,
      logic [WORD_W-1:0] entry, logic flag, logic [CODE_W-1:0] code);
    page_result_t     res;
    logic [L1_AW-1:0] i1;
    logic [L2_AW-1:0] i2;
    logic [WORD_W-1:0] word;
    logic [1:0]       l2_type;
    int unsigned      slot;
    int unsigned      hit;
    bit               go;
    res = '0;
    res.status = ST_INSERTED;
    i1 = va[31:20];
    i2 = va[19:12];
    slot = 0;
    go = 1'b1;
    if (kind != KIND_INSERT) begin
      if (code == FAULT_PAGE || code == FAULT_SECTION) begin
        entry = {va[31:12], AP_ALL_RW | 12'(TYPE_SMALL)};
        flag = 1'b1;
      end else begin
        res.status = ST_UNKNOWN;
        go = 1'b0;
      end
    end
    if (go) begin
      word = l1_table[i1];
      if (word[1:0] == TYPE_NONE) begin
        if (tables_taken >= POOL_N) begin
          res.status = ST_POOL_FULL;
        end else begin
          slot = tables_taken;
          tables_taken++;
          coarse_mem[slot*COARSE_ENTRIES + i2] = entry;
          l1_table[i1] = {BASE_W'(pool_base + slot), 10'(L1_DEFAULT) | 10'(TYPE_COARSE)};
          res.created = 1'b1;
        end
      end else if (resolve_table(word, hit)) begin
        slot = hit;
        l2_type = coarse_mem[slot*COARSE_ENTRIES + i2][1:0];
        if (l2_type == TYPE_SMALL) begin
          res.status = flag ? ST_DUPLICATE : ST_EXISTS;
        end else if (l2_type != TYPE_NONE) begin
          res.status = ST_UNSUPPORTED;
        end else begin
          coarse_mem[slot*COARSE_ENTRIES + i2] = entry;
        end
      end else begin
        // not a coarse table in the taken pool: a stale coarse base or another descriptor type
        res.status = ST_UNSUPPORTED;
      end
    end
    res.slot = SLOT_OUT_W'(slot);
    res.l1_word = l1_table[i1];
    if (resolve_table(res.l1_word, hit)) begin
      res.l2_word = coarse_mem[hit*COARSE_ENTRIES + i2];
    end
    return res;
  endfunction

  // result side: random stalls, every accepted beat checked against the oldest prediction
  always @(posedge clk) begin
    page_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no prediction pending");
        errors++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_if.status);
          errors++;
        end
        if (out_if.created_table !== want.created) begin
          $error("created_table: expected %0d, got %0d", want.created, out_if.created_table);
          errors++;
        end
        if (out_if.pool_slot !== want.slot) begin
          $error("pool_slot: expected %0d, got %0d", want.slot, out_if.pool_slot);
          errors++;
        end
        if (out_if.first_level_word !== want.l1_word) begin
          $error("first_level_word: expected %h, got %h", want.l1_word,
                 out_if.first_level_word);
          errors++;
        end
        if (out_if.second_level_word !== want.l2_word) begin
          $error("second_level_word: expected %h, got %h", want.l2_word,
                 out_if.second_level_word);
          errors++;
        end
      end
    end
    out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // valid is left high after a beat so back-to-back items need no second assignment
  task automatic send_item(logic kind, logic [WORD_W-1:0] va, logic [WORD_W-1:0] entry,
      logic flag, logic [CODE_W-1:0] code);
    page_result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.kind            <= kind;
    in_if.virtual_address <= va;
    in_if.page_entry      <= entry;
    in_if.flag_duplicates <= flag;
    in_if.fault_code      <= code;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    res = predict_insert(kind, va, entry, flag, code);
    expected_results.push_back(res);
    status_count[res.status]++;
    items_sent++;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (expected_results.size() != 0) begin
      $error("%0d results still missing after drain", expected_results.size());
      errors++;
    end
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_base(logic [BASE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    pool_base = value;
    cfg_we    <= 1'b0;
  endtask

  // fresh tables, overwrite of an empty entry, exists, duplicate, foreign entry types
  task automatic test_fresh_tables();
    send_item(KIND_INSERT, '1, '1, 1'b1, '0);
    send_item(KIND_INSERT, '1, 32'h1234_5002, 1'b0, '1);
    send_item(KIND_INSERT, '0, '0, 1'b0, '0);
    send_item(KIND_INSERT, '0, 32'hABCD_E002, 1'b0, '0);
    send_item(KIND_INSERT, '0, 32'h5555_5556, 1'b0, '0);
    send_item(KIND_INSERT, '0, 32'hAAAA_AAAA, 1'b1, '0);
    send_item(KIND_INSERT, 32'h0000_1FFF, {30'h0, TYPE_COARSE}, 1'b0, '0);
    send_item(KIND_INSERT, 32'h0000_1000, {30'h0, TYPE_SMALL}, 1'b1, '0);
  endtask

  task automatic test_fault_events();
    logic [CODE_W-1:0] code;
    int n;
    send_item(~KIND_INSERT, 32'h0010_2345, $urandom, 1'b0, FAULT_PAGE);
    send_item(~KIND_INSERT, 32'h0010_2FFF, $urandom, 1'b0, FAULT_SECTION);
    send_item(~KIND_INSERT, 32'h0010_3000, $urandom, 1'b1, FAULT_SECTION);
    send_item(~KIND_INSERT, '1, $urandom, 1'b1, '0);
    send_item(~KIND_INSERT, 32'h0020_0000, $urandom, 1'b0, '1);
    for (n = 0; n < 2; n++) begin
      do code = CODE_W'($urandom); while (code == FAULT_PAGE || code == FAULT_SECTION);
      send_item(~KIND_INSERT, $urandom, $urandom, 1'($urandom), code);
    end
  endtask

  // moving the pool base makes old first-level words point at other or no slots
  task automatic test_base_alias();
    wait_drained();
    write_base(22'h3F_FFFE);
    send_item(KIND_INSERT, 32'hFFF0_0000, 32'h0000_0002, 1'b0, '0);
    send_item(KIND_INSERT, 32'h0010_2000, 32'h0000_0002, 1'b0, '0);
    send_item(KIND_INSERT, 32'h8000_0000, 32'h8000_0FF2, 1'b0, '0);
    send_item(KIND_INSERT, 32'h0010_2000, 32'h0000_0002, 1'b1, '0);
  endtask

  task automatic run_random(int phase, int count, int src_pct, int sink_pct,
      logic [BASE_W-1:0] base);
    logic [L1_AW-1:0]  i1;
    logic [L2_AW-1:0]  i2;
    logic [WORD_W-1:0] entry;
    logic [CODE_W-1:0] code;
    logic              kind;
    int                roll;
    int                h;
    int                n;
    wait_drained();
    write_base(base);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (h = 0; h < HOT_N; h++) begin
      hot_index[phase][h] = (phase == 2) ? hot_index[0][h] : L1_AW'($urandom);
    end
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 88) begin
        i1 = hot_index[phase][$urandom_range(HOT_N-1)];
      end else if (roll < 97) begin
        i1 = hot_index[$urandom_range(phase)][$urandom_range(HOT_N-1)];
      end else begin
        i1 = L1_AW'($urandom);
      end
      // crowd onto a few second-level slots so entries get revisited
      i2 = ($urandom_range(99) < 75) ? L2_AW'($urandom_range(7)) : L2_AW'($urandom);
      entry = $urandom;
      roll = $urandom_range(99);
      if (roll < 50) entry[1:0] = TYPE_SMALL;
      else if (roll < 70) entry[1:0] = TYPE_NONE;
      else if (roll < 85) entry[1:0] = TYPE_COARSE;
      else entry[1:0] = ~TYPE_NONE;
      kind = ($urandom_range(99) < 75) ? KIND_INSERT : ~KIND_INSERT;
      roll = $urandom_range(99);
      if (roll < 35) code = FAULT_PAGE;
      else if (roll < 70) code = FAULT_SECTION;
      else code = CODE_W'($urandom);
      send_item(kind, {i1, i2, 12'($urandom)}, entry, 1'($urandom), code);
    end
  endtask

  // take the rest of the pool, then a few more fresh indexes that must report it full
  task automatic test_pool_full();
    logic [L1_AW-1:0] i1;
    int extra;
    extra = 0;
    while (extra < 3) begin
      i1 = L1_AW'($urandom);
      if (l1_table[i1][1:0] == TYPE_NONE) begin
        if (tables_taken >= POOL_N) extra++;
        send_item((extra == 2) ? ~KIND_INSERT : KIND_INSERT, {i1, 20'($urandom)}, $urandom,
                  1'($urandom), FAULT_PAGE);
      end
    end
  endtask

  initial begin
    int k;
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_wdata              = '0;
    in_if.valid            = 1'b0;
    in_if.kind             = KIND_INSERT;
    in_if.virtual_address  = '0;
    in_if.page_entry       = '0;
    in_if.flag_duplicates  = 1'b0;
    in_if.fault_code       = '0;
    out_if.ready           = 1'b0;
    src_idle_pct           = 24;
    sink_idle_pct          = 60;
    items_sent             = 0;
    results_checked        = 0;
    errors                 = 0;
    tables_taken           = 0;
    pool_base              = '0;
    for (k = 0; k < L1_DEPTH; k++) l1_table[k] = L1_DEFAULT;
    for (k = 0; k < POOL_N*COARSE_ENTRIES; k++) coarse_mem[k] = '0;
    for (k = 0; k < 8; k++) status_count[k] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // top of the base range so the second table wraps to base zero
    write_base('1);

    test_fresh_tables();
    test_fault_events();
    test_base_alias();
    run_random(0, PHASE_ITEMS, 24, 60, '0);
    run_random(1, PHASE_ITEMS, 60, 24, BASE_W'($urandom_range(32'h3F_FFFE, 1)));
    test_pool_full();
    run_random(2, PHASE_ITEMS, 0, 0, '0);
    wait_drained();

    $display("%0d items, %0d results checked, %0d of %0d coarse tables taken",
             items_sent, results_checked, tables_taken, POOL_N);
    $display("inserted %0d, exists %0d, duplicate %0d, unsupported %0d, full %0d, unknown %0d",
             status_count[ST_INSERTED], status_count[ST_EXISTS], status_count[ST_DUPLICATE],
             status_count[ST_UNSUPPORTED], status_count[ST_POOL_FULL],
             status_count[ST_UNKNOWN]);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
